### hw/rtl/kab_pkg.sv
`timescale 1ns / 1ps

package kab_pkg;

  localparam int NODES_DEF  = 256;
  localparam int LEVELS_DEF = 8;
  localparam int ID_W       = 8;
  localparam int DIST_W     = 10;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // one jump table entry: valid flag over a node id
  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] id;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_QRY,
    ST_QOUT
  } st_t;

endpackage

### hw/rtl/kab_ram.sv
`timescale 1ns / 1ps

module kab_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### hw/rtl/kth_ancestor_binary_lifting.sv
`timescale 1ns / 1ps
// load: writes the node's row one level per cycle; level 0 is the parent entry, each higher
//   level is read from the RAM via the level below and written back the next cycle
// query: climbs the levels in order, one RAM read per set distance bit, then waits in ST_QOUT
//   for a free output register; a bad node or distance or a climb past the root gives not-found
// one transaction in flight: in_ready is high only in ST_IDLE
// synchronous active-low reset clears control state; the jump table is not cleared

module kth_ancestor_binary_lifting #(
  parameter int NODES  = kab_pkg::NODES_DEF,
  parameter int LEVELS = kab_pkg::LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [kab_pkg::ID_W-1:0]  in_node_id,
  input  logic [kab_pkg::ID_W-1:0]  in_parent_node,
  input  logic                      in_has_parent,
  input  logic [kab_pkg::DIST_W-1:0] in_distance,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [kab_pkg::ID_W-1:0]  out_ancestor_node,
  output logic                      out_found
);

  import kab_pkg::*;

  localparam int NODE_W = $clog2(NODES);
  localparam int LA_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LC_W   = $clog2(LEVELS + 1);
  localparam int AW     = NODE_W + LA_W;
  localparam int DEPTH  = NODES << LA_W;

  localparam logic [16:0]     NODES_L  = 17'(NODES);
  localparam logic [LC_W-1:0] LAST_LVL = LC_W'(LEVELS - 1);
  localparam logic [LC_W-1:0] END_LVL  = LC_W'(LEVELS);

  st_t                st_r, st_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [LC_W-1:0]    lvl_r, lvl_nxt;
  ent_t               cur_r, cur_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               fwd_r, fwd_nxt;
  logic [LEVELS-1:0]  dist_r, dist_nxt;
  logic [ID_W-1:0]    res_anc_r, res_anc_nxt;
  logic               res_found_r, res_found_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_anc_r, out_anc_nxt;
  logic               out_found_r, out_found_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;
  ent_t               rd_ent, cur;

  logic [15:0]        in_node16, in_par16, cur_id16, dist16;
  logic [NODE_W-1:0]  in_idx, cur_idx;
  logic               in_node_ok, in_par_ok, cur_id_ok, dist_ok;
  logic [LA_W-1:0]    lvl_a;

  kab_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (cur),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  // a read issued in the same cycle as the write of that entry sees the held value
  assign rd_ent = fwd_r ? cur_r : ent_t'(ram_rdata);
  assign cur    = rd_pend_r ? rd_ent : cur_r;

  assign in_node16  = {8'b0, in_node_id};
  assign in_par16   = {8'b0, in_parent_node};
  assign cur_id16   = {8'b0, cur.id};
  assign dist16     = {6'b0, in_distance};
  assign in_idx     = in_node16[NODE_W-1:0];
  assign cur_idx    = cur_id16[NODE_W-1:0];
  assign in_node_ok = {1'b0, in_node16} < NODES_L;
  assign in_par_ok  = {1'b0, in_par16} < NODES_L;
  assign cur_id_ok  = {1'b0, cur_id16} < NODES_L;
  assign dist_ok    = ((32'(in_distance) >> LEVELS) == 32'd0);
  assign lvl_a      = lvl_r[LA_W-1:0];

  assign in_ready          = (st_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ancestor_node = out_anc_r;
  assign out_found         = out_found_r;

  always_comb begin
    st_nxt        = st_r;
    node_nxt      = node_r;
    lvl_nxt       = lvl_r;
    cur_nxt       = cur_r;
    rd_pend_nxt   = rd_pend_r;
    fwd_nxt       = fwd_r;
    dist_nxt      = dist_r;
    res_anc_nxt   = res_anc_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_anc_nxt   = out_anc_r;
    out_found_nxt = out_found_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = {node_r, lvl_a};
    ram_raddr     = {cur_idx, lvl_a};

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          node_nxt    = in_idx;
          lvl_nxt     = '0;
          rd_pend_nxt = 1'b0;
          fwd_nxt     = 1'b0;
          dist_nxt    = dist16[LEVELS-1:0];
          if (in_req_type == REQ_LOAD) begin
            // out-of-range node: the load is dropped
            if (in_node_ok) begin
              cur_nxt.vld = in_has_parent && in_par_ok;
              cur_nxt.id  = (in_has_parent && in_par_ok) ? in_parent_node : '0;
              st_nxt      = ST_LOAD;
            end
          end else if (in_node_ok && dist_ok) begin
            cur_nxt.vld = 1'b1;
            cur_nxt.id  = in_node_id;
            st_nxt      = ST_QRY;
          end else begin
            res_anc_nxt   = '0;
            res_found_nxt = 1'b0;
            st_nxt        = ST_QOUT;
          end
        end
      end
      ST_LOAD: begin
        ram_we = 1'b1;
        if (lvl_r == LAST_LVL) begin
          rd_pend_nxt = 1'b0;
          fwd_nxt     = 1'b0;
          st_nxt      = ST_IDLE;
        end else begin
          lvl_nxt = lvl_r + LC_W'(1);
          if (cur.vld && cur_id_ok) begin
            ram_re      = 1'b1;
            rd_pend_nxt = 1'b1;
            fwd_nxt     = (cur_idx == node_r);
            cur_nxt     = cur;
          end else begin
            rd_pend_nxt = 1'b0;
            fwd_nxt     = 1'b0;
            cur_nxt     = '0;
          end
        end
      end
      ST_QRY: begin
        if (rd_pend_r && (!cur.vld || !cur_id_ok)) begin
          // climb went past the root
          res_anc_nxt   = '0;
          res_found_nxt = 1'b0;
          rd_pend_nxt   = 1'b0;
          st_nxt        = ST_QOUT;
        end else if (lvl_r == END_LVL) begin
          res_anc_nxt   = cur.id;
          res_found_nxt = 1'b1;
          rd_pend_nxt   = 1'b0;
          st_nxt        = ST_QOUT;
        end else begin
          lvl_nxt     = lvl_r + LC_W'(1);
          cur_nxt     = cur;
          rd_pend_nxt = dist_r[lvl_a];
          ram_re      = dist_r[lvl_a];
        end
      end
      ST_QOUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_anc_nxt   = res_anc_r;
          out_found_nxt = res_found_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rd_pend_r   <= rd_pend_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    lvl_r       <= lvl_nxt;
    cur_r       <= cur_nxt;
    dist_r      <= dist_nxt;
    res_anc_r   <= res_anc_nxt;
    res_found_r <= res_found_nxt;
    out_anc_r   <= out_anc_nxt;
    out_found_r <= out_found_nxt;
  end

  a_out_from_qout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_QOUT)
    else $error("result appeared without a finished query");

  a_write_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> st_r == ST_LOAD)
    else $error("jump table written outside a load");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_anc_r == '0)
    else $error("not-found result carries a nonzero ancestor");

  a_load_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_LOAD |-> lvl_r <= LAST_LVL)
    else $error("load level counter ran past the last level");

  a_fwd_only_pend: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> rd_pend_r && st_r == ST_LOAD)
    else $error("forwarding flagged without a pending load read");

endmodule
